// ===== src/text_console_writer_assert.svh =====
// ---------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros used by the console writer checker.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

   typedef enum logic [1:0] {
      OP_PUT        = 2'd0,
      OP_CLEAR      = 2'd1,
      OP_SET_CURSOR = 2'd2,
      OP_READ       = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  row_sel;
      logic [COL_W-1:0]  col_sel;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] read_char;
      logic [ROW_W-1:0]  cursor_row_now;
      logic [COL_W-1:0]  cursor_col_now;
      logic              scrolled;
      logic              bad_address;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SCROLL,
      ST_STORE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_NEXT_ROW,
      CMD_BACKSPACE,
      CMD_STORE,
      CMD_HOME,
      CMD_SWEEP_ROW,
      CMD_SWEEP_ALL,
      CMD_SET_CURSOR,
      CMD_READ,
      CMD_RESULT
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   is_newline;
      logic   is_backspace;
      logic   col_zero;
      logic   col_full;
      logic   row_last;
      logic   read_ok;
      logic   sweep_last_row;
      logic   sweep_last_all;
      logic   rsp_stall;
   } status_type;

endpackage

// ===== src/tcw_chan_if.sv =====
// ---------------------------------------------------------------------------
// tcw_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ---------------------------------------------------------------------------
interface tcw_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== src/text_console_writer.sv =====
// ---------------------------------------------------------------------------
// text_console_writer
// Character-cell text console of COLUMNS x ROWS bytes with a write cursor.
//
//   channel  dir  payload                                   word
//   req_*    in   op, char_code, row_sel, col_sel            one operation
//   rsp_*    out  read_char, cursor_row_now, cursor_col_now,  one result
//                 scrolled, bad_address
//
// A scroll blanks the old top row, which becomes the new bottom row, and a
// clear blanks every cell: cells are blanked one per cycle through the
// single memory port. After reset a clearing pass blanks every cell before
// req_ready rises. A new word is taken while a result waits; its result
// waits for rsp_ready.
// ---------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic         clock,
   input logic         reset,
   tcw_chan_if.sink    req_chan,
   tcw_chan_if.source  rsp_chan
);
   import tcw_pkg::*;

   status_type      status;
   cmd_type         cmd;
   logic            ctl_ready;
   logic            dp_rsp_valid;
   rsp_payload_type dp_rsp_data;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .req_ready (ctl_ready),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_chan.data),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .rsp_valid (dp_rsp_valid),
      .rsp_data  (dp_rsp_data)
   );

   assign req_chan.ready = ctl_ready;
   assign rsp_chan.valid = dp_rsp_valid;
   assign rsp_chan.data  = dp_rsp_data;

endmodule

// ===== src/tcw_ctrl.sv =====
// ---------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console writer: decodes a captured word and steps the
// datapath through cursor moves, cell reads and writes, row blanking and full clears.
// ---------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  tcw_pkg::status_type status,
   output logic                req_ready,
   output tcw_pkg::cmd_type    cmd
);
   import tcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd = CMD_SWEEP_ALL;
            if (status.sweep_last_all) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_CAPTURE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               OP_PUT: begin
                  priority if (status.is_newline) begin
                     cmd      = CMD_NEXT_ROW;
                     state_in = status.row_last ? ST_SCROLL : ST_DONE;
                  end else if (status.is_backspace) begin
                     if (!status.col_zero) cmd = CMD_BACKSPACE;
                     state_in = ST_DONE;
                  end else if (status.col_full) begin
                     cmd      = CMD_NEXT_ROW;
                     state_in = status.row_last ? ST_SCROLL : ST_STORE;
                  end else begin
                     cmd      = CMD_STORE;
                     state_in = ST_DONE;
                  end
               end
               OP_CLEAR: begin
                  cmd      = CMD_HOME;
                  state_in = ST_CLEAR;
               end
               OP_SET_CURSOR: begin
                  cmd      = CMD_SET_CURSOR;
                  state_in = ST_DONE;
               end
               OP_READ: begin
                  if (status.read_ok) cmd = CMD_READ;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCROLL: begin
            cmd = CMD_SWEEP_ROW;
            if (status.sweep_last_row) begin
               state_in = status.is_newline ? ST_DONE : ST_STORE;
            end
         end
         ST_STORE: begin
            cmd      = CMD_STORE;
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            cmd = CMD_SWEEP_ALL;
            if (status.sweep_last_all) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_stall) begin
               cmd      = CMD_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

// ===== src/tcw_datapath.sv =====
// ---------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor, top-row pointer, sweep counter and result register of
// the console writer, driven one command per cycle.
// ---------------------------------------------------------------------------
module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcw_pkg::cmd_type         cmd,
   input  tcw_pkg::req_payload_type req_data,
   input  logic                     rsp_ready,
   output tcw_pkg::status_type      status,
   output logic                     rsp_valid,
   output tcw_pkg::rsp_payload_type rsp_data
);
   import tcw_pkg::*;

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int SWEEP_W = (ADDR_W > COL_W) ? ADDR_W : COL_W;

   logic [CHAR_W-1:0] mem [CELLS];
   logic [CHAR_W-1:0] rdata_ff;

   req_payload_type   req_ff, req_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic              scr_ff, scr_in;

   logic [ROW_W-1:0]  lrow;
   logic [COL_W-1:0]  lcol;
   logic [ROW_W:0]    prow_sum;
   logic [ROW_W-1:0]  prow;
   logic [ADDR_W-1:0] row_addr;
   logic [ADDR_W-1:0] cell_addr;
   logic              mem_we;
   logic              mem_re;
   logic [CHAR_W-1:0] mem_wdata;
   logic              is_read;

   // logical row maps to physical row (row + top) mod ROWS
   always_comb begin
      unique case (cmd)
         CMD_BACKSPACE: begin
            lrow = cursor_row_ff;
            lcol = cursor_col_ff - 1'b1;
         end
         CMD_READ: begin
            lrow = req_ff.row_sel;
            lcol = req_ff.col_sel;
         end
         CMD_SWEEP_ROW: begin
            lrow = '0;
            lcol = sweep_ff[COL_W-1:0];
         end
         default: begin
            lrow = cursor_row_ff;
            lcol = cursor_col_ff;
         end
      endcase
      prow_sum = {1'b0, lrow} + {1'b0, top_ff};
      if (prow_sum >= (ROW_W+1)'(ROWS)) begin
         prow = ROW_W'(prow_sum - (ROW_W+1)'(ROWS));
      end else begin
         prow = prow_sum[ROW_W-1:0];
      end
      row_addr  = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(lcol);
      cell_addr = (cmd == CMD_SWEEP_ALL) ? sweep_ff[ADDR_W-1:0] : row_addr;
      mem_we    = (cmd == CMD_BACKSPACE) || (cmd == CMD_STORE) ||
                  (cmd == CMD_SWEEP_ROW) || (cmd == CMD_SWEEP_ALL);
      mem_re    = (cmd == CMD_READ);
      mem_wdata = (cmd == CMD_STORE) ? req_ff.char_code : CH_SPACE;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[cell_addr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[cell_addr];
   end

   always_comb begin
      status.op             = req_ff.op;
      status.is_newline     = (req_ff.char_code == CH_NEWLINE);
      status.is_backspace   = (req_ff.char_code == CH_BACKSPACE);
      status.col_zero       = (cursor_col_ff == '0);
      status.col_full       = (cursor_col_ff >= COL_W'(COLUMNS));
      status.row_last       = (cursor_row_ff == ROW_W'(ROWS - 1));
      status.read_ok        = (req_ff.row_sel < ROW_W'(ROWS)) &&
                              (req_ff.col_sel < COL_W'(COLUMNS));
      status.sweep_last_row = (sweep_ff == SWEEP_W'(COLUMNS - 1));
      status.sweep_last_all = (sweep_ff == SWEEP_W'(CELLS - 1));
      status.rsp_stall      = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      req_in        = req_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      top_in        = top_ff;
      sweep_in      = sweep_ff;
      scr_in        = scr_ff;
      is_read       = (req_ff.op == OP_READ);
      unique case (cmd)
         CMD_CAPTURE: begin
            req_in = req_data;
            scr_in = 1'b0;
         end
         CMD_NEXT_ROW: begin
            cursor_col_in = '0;
            if (status.row_last) begin
               scr_in = 1'b1;
            end else begin
               cursor_row_in = cursor_row_ff + 1'b1;
            end
         end
         CMD_BACKSPACE: begin
            cursor_col_in = cursor_col_ff - 1'b1;
         end
         CMD_STORE: begin
            cursor_col_in = cursor_col_ff + 1'b1;
         end
         CMD_HOME: begin
            cursor_row_in = '0;
            cursor_col_in = '0;
            top_in        = '0;
         end
         CMD_SWEEP_ROW: begin
            if (status.sweep_last_row) begin
               sweep_in = '0;
               top_in   = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         CMD_SWEEP_ALL: begin
            sweep_in = status.sweep_last_all ? '0 : sweep_ff + 1'b1;
         end
         CMD_SET_CURSOR: begin
            if (req_ff.row_sel < ROW_W'(ROWS)) cursor_row_in = req_ff.row_sel;
            if (req_ff.col_sel < COL_W'(COLUMNS)) cursor_col_in = req_ff.col_sel;
         end
         CMD_RESULT: begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.read_char      = (is_read && status.read_ok) ? rdata_ff : '0;
            rsp_data_in.cursor_row_now = cursor_row_ff;
            rsp_data_in.cursor_col_now = cursor_col_ff;
            rsp_data_in.scrolled       = scr_ff;
            rsp_data_in.bad_address    = is_read && !status.read_ok;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         top_ff        <= '0;
         sweep_ff      <= '0;
         scr_ff        <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         top_ff        <= top_in;
         sweep_ff      <= sweep_in;
         scr_ff        <= scr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/tcw_checker.sv =====
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tcw_pkg::rsp_payload_type rsp_data
);
   import tcw_pkg::*;

   `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word changed while stalled")
   `TCW_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted a second word without decoding the first")
   `TCW_ASSERT_IMPLY(a_cursor_range, rsp_valid, (rsp_data.cursor_row_now < ROW_W'(ROWS)) && (rsp_data.cursor_col_now <= COL_W'(COLUMNS)), "cursor outside grid")
   `TCW_ASSERT_IMPLY(a_bad_zero, rsp_valid && rsp_data.bad_address, rsp_data.read_char == '0, "bad read returned data")
   `TCW_ASSERT_IMPLY(a_scroll_row, rsp_valid && rsp_data.scrolled, rsp_data.cursor_row_now == ROW_W'(ROWS - 1), "scroll left cursor off bottom row")

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Checks the text console writer against a behavioral model of the console
// grid, cursor and scroll pointer. Words are driven from a queue through a
// valid/ready driver with random idle bursts; every result is compared field
// by field with the model's prediction for the word that caused it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import tcw_pkg::*;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int RANDOM_CMDS = 1900;
   localparam int CALM_TAIL   = 150;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock;
   logic reset;

   tcw_chan_if #(.payload_type(req_payload_type)) req_if ();
   tcw_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   text_console_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // console model: physical rows, logical row r at (r + top_row) mod ROWS
   logic [CHAR_W-1:0] screen [ROWS][COLUMNS];
   int                cur_row;
   int                cur_col;
   int                top_row;

   req_payload_type console_cmds [$];
   rsp_payload_type expected_results [$];

   int mismatch_count;
   int cycle_count;
   int req_gap;
   int rsp_gap;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void blank_screen();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLUMNS; c++)
            screen[r][c] = CH_SPACE;
      cur_row = 0;
      cur_col = 0;
      top_row = 0;
   endfunction

   function automatic int phys_row(int r);
      return (r + top_row) % ROWS;
   endfunction

   function automatic logic advance_row();
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int c = 0; c < COLUMNS; c++)
            screen[top_row][c] = CH_SPACE;
         top_row = (top_row + 1) % ROWS;
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_payload_type console_step(req_payload_type w);
      rsp_payload_type res;
      res = '0;
      case (w.op)
         OP_PUT: begin
            if (w.char_code == CH_NEWLINE) begin
               cur_col = 0;
               res.scrolled = advance_row();
            end else if (w.char_code == CH_BACKSPACE) begin
               if (cur_col > 0) begin
                  cur_col--;
                  screen[phys_row(cur_row)][cur_col] = CH_SPACE;
               end
            end else begin
               if (cur_col >= COLUMNS) begin
                  cur_col = 0;
                  res.scrolled = advance_row();
               end
               screen[phys_row(cur_row)][cur_col] = w.char_code;
               cur_col++;
            end
         end
         OP_CLEAR: blank_screen();
         OP_SET_CURSOR: begin
            if (w.row_sel < ROWS)
               cur_row = w.row_sel;
            if (w.col_sel < COLUMNS)
               cur_col = w.col_sel;
         end
         default: begin
            if (w.row_sel < ROWS && w.col_sel < COLUMNS)
               res.read_char = screen[phys_row(w.row_sel)][w.col_sel];
            else
               res.bad_address = 1'b1;
         end
      endcase
      res.cursor_row_now = cur_row[ROW_W-1:0];
      res.cursor_col_now = cur_col[COL_W-1:0];
      return res;
   endfunction

   task automatic add_cmd(op_type op, int ch, int r, int c);
      req_payload_type w;
      w.op        = op;
      w.char_code = ch[CHAR_W-1:0];
      w.row_sel   = r[ROW_W-1:0];
      w.col_sel   = c[COL_W-1:0];
      console_cmds.push_back(w);
   endtask

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   function automatic int pick_row();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 31);
      if ($urandom_range(0, 3) == 0)
         return ROWS - 1;
      return $urandom_range(0, ROWS - 1);
   endfunction

   function automatic int pick_col();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 127);
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(COLUMNS - 3, COLUMNS - 1);
      return $urandom_range(0, COLUMNS - 1);
   endfunction

   function automatic logic calm_tail();
      return console_cmds.size() < CALM_TAIL;
   endfunction

   task automatic build_random_cmds();
      int pick;
      int ch;
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         pick = $urandom_range(0, 999);
         if (pick < 8) begin
            add_cmd(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 31),
                    $urandom_range(0, 127));
         end else if (pick < 110) begin
            add_cmd(OP_SET_CURSOR, $urandom_range(0, 255), pick_row(), pick_col());
         end else if (pick < 360) begin
            add_cmd(OP_READ, $urandom_range(0, 255), pick_row(), pick_col());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
               ch = CH_NEWLINE;
            else if (pick < 18)
               ch = CH_BACKSPACE;
            else
               ch = $urandom_range(0, 255);
            add_cmd(OP_PUT, ch, $urandom_range(0, 31), $urandom_range(0, 127));
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_results.push_back(console_step(req_if.data));
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (console_cmds.size() > 0 && !calm_tail() &&
                         $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 9) - 1;
               req_if.valid <= 1'b0;
            end else if (console_cmds.size() > 0) begin
               req_if.data  <= console_cmds.pop_front();
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result word with none expected, actual %p", $time,
                        rsp_if.data);
               mismatch_count++;
            end else begin
               rsp_payload_type want;
               want = expected_results.pop_front();
               compare_field("read_char", want.read_char, rsp_if.data.read_char);
               compare_field("cursor_row_now", want.cursor_row_now,
                             rsp_if.data.cursor_row_now);
               compare_field("cursor_col_now", want.cursor_col_now,
                             rsp_if.data.cursor_col_now);
               compare_field("scrolled", want.scrolled, rsp_if.data.scrolled);
               compare_field("bad_address", want.bad_address, rsp_if.data.bad_address);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else if (!calm_tail() && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(1, 9) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      rsp_if.ready   = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      blank_screen();

      // corners and bad addresses on the blank screen
      add_cmd(OP_READ, 8'h00, 0, 0);
      add_cmd(OP_READ, 8'hFF, ROWS - 1, COLUMNS - 1);
      add_cmd(OP_READ, 8'h00, ROWS, 0);
      add_cmd(OP_READ, 8'h00, 0, COLUMNS);
      add_cmd(OP_READ, 8'h00, 31, 127);
      // backspace at column 0, extreme bytes, backspace blanking
      add_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
      add_cmd(OP_PUT, 8'hFF, 31, 127);
      add_cmd(OP_PUT, 8'h00, 0, 0);
      add_cmd(OP_PUT, "A", 0, 0);
      add_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
      add_cmd(OP_READ, 8'h00, 0, 2);
      // set cursor, row and column checked separately
      add_cmd(OP_SET_CURSOR, 8'h00, 31, 127);
      add_cmd(OP_SET_CURSOR, 8'h00, 3, 127);
      add_cmd(OP_SET_CURSOR, 8'h00, 31, COLUMNS - 1);
      // full line, backspace from the end, wrap
      add_cmd(OP_PUT, "Z", 0, 0);
      add_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
      add_cmd(OP_PUT, "Y", 0, 0);
      add_cmd(OP_PUT, "X", 0, 0);
      // wrap and newline on the last row scroll
      add_cmd(OP_SET_CURSOR, 8'h00, ROWS - 1, COLUMNS - 1);
      add_cmd(OP_PUT, "Q", 0, 0);
      add_cmd(OP_PUT, "R", 0, 0);
      add_cmd(OP_PUT, CH_NEWLINE, 0, 0);
      add_cmd(OP_READ, 8'h00, ROWS - 3, COLUMNS - 1);
      add_cmd(OP_CLEAR, 8'h00, 0, 0);
      add_cmd(OP_READ, 8'h00, ROWS - 3, COLUMNS - 1);
      build_random_cmds();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (console_cmds.size() > 0 || req_if.valid || expected_results.size() > 0)
         @(negedge clock);
      repeat (100) @(negedge clock);

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
